// ===== rtl/vdi_pkg.sv =====
// ----------------------------------------------------------------------------
// vdi_pkg
// shared constants and types for the vertex deduplication indexer
// ----------------------------------------------------------------------------
package vdi_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int WORD_W      = 64;
    localparam int NUM_WORDS   = 6;
    localparam int VTX_W       = WORD_W * NUM_WORDS;
    // position, uv and normal words, tangent words above them
    localparam int CORE_W      = WORD_W * 4;

    localparam int OUT_IDX_W   = 12;
    localparam int OUT_CNT_W   = 13;
    localparam int OUT_DATA_W  = 32;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_IDX_W - 2 - OUT_CNT_W;

    typedef struct packed {
        logic             som;
        logic [VTX_W-1:0] vtx;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             is_new;
        logic             overflow;
        logic [CNT_W-1:0] count;
    } t_result;

endpackage

// ===== rtl/vertex_dedup_indexer.sv =====
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// builds an indexed vertex list by linear search of a table of unique vertices
// ----------------------------------------------------------------------------
// channel   direction  handshake                payload
// s         in         i_s_tvalid / o_s_tready  i_s_tdata (vertex words), i_s_tuser (start)
// m         out        o_m_tvalid / i_m_tready  o_m_tdata (index, flags, count)
// cfg       in         i_cfg_we                 i_cfg_wdata (use_tangents)
//
// a search reads the table in order from entry 0 and stops at the first match
// on a hit; a miss scans every entry, then appends the item, or flags
// overflow if the table is full
// the single table read port visits one entry per cycle
// reset empties the table at once through its entry count, no clearing pass
// a two-entry queue takes items while a search runs; the result register
// holds a result until taken, and the next search starts once it is free
// ----------------------------------------------------------------------------
module vertex_dedup_indexer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // pos_xy, pos_z_tex_u, nor_xy, nor_z_tex_v, tan_xy, tan_z_hand
    input  logic [vdi_pkg::VTX_W-1:0]      i_s_tdata,
    // start_of_mesh
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // vertex_index, is_new, overflow, unique_count, zero pad
    output logic [vdi_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    logic             r_use_tan;
    logic             q_valid;
    vdi_pkg::t_item   q_item;
    logic             q_pop;
    vdi_pkg::t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_tan <= 1'b0;
        end else if (i_cfg_we) begin
            r_use_tan <= i_cfg_wdata;
        end
    end

    vdi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    vdi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_use_tan   (r_use_tan),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_res_valid (o_m_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_tready)
    );

    assign o_m_tdata = {{vdi_pkg::OUT_PAD_W{1'b0}},
                        vdi_pkg::OUT_CNT_W'(res.count),
                        res.overflow,
                        res.is_new,
                        vdi_pkg::OUT_IDX_W'(res.idx)};

endmodule

// ===== rtl/vdi_ram.sv =====
// ----------------------------------------------------------------------------
// vdi_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module vdi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vdi_front.sv =====
// ----------------------------------------------------------------------------
// vdi_front
// input side: takes items and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module vdi_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [vdi_pkg::VTX_W-1:0] i_s_tdata,
    input  logic                      i_s_tuser,
    output logic                      o_q_valid,
    output vdi_pkg::t_item            o_q_item,
    input  logic                      i_q_pop
);

    vdi_pkg::t_item r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_fill;
    logic           push;

    assign o_s_tready = (r_fill != 2'd2);
    assign push       = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_fill != 2'd0);
    assign o_q_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr].som <= i_s_tuser;
            r_mem[r_wr_ptr].vtx <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !i_q_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!push && i_q_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/vdi_back.sv =====
// ----------------------------------------------------------------------------
// vdi_back
// search engine: linear scan of the vertex table; when not full, append on miss
// ----------------------------------------------------------------------------
module vdi_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_use_tan,
    input  logic             i_q_valid,
    input  vdi_pkg::t_item   i_q_item,
    output logic             o_q_pop,
    output logic             o_res_valid,
    output vdi_pkg::t_result o_res,
    input  logic             i_res_ready
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic                          r_state;
    logic [vdi_pkg::VTX_W-1:0]     r_vtx;
    logic [vdi_pkg::CNT_W-1:0]     r_count;
    logic [vdi_pkg::CNT_W-1:0]     r_addr;
    logic                          r_pend;
    logic [vdi_pkg::IDX_W-1:0]     r_pend_addr;
    logic                          r_out_valid;
    vdi_pkg::t_result              r_out;

    logic [vdi_pkg::VTX_W-1:0]     rd_data;
    logic                          issue;
    logic                          match;
    logic                          done_miss;
    logic                          full;
    logic                          we;

    always_comb begin
        o_q_pop   = (r_state == ST_IDLE) && i_q_valid && !r_out_valid;
        issue     = (r_state == ST_SEARCH) && (r_addr < r_count);
        match     = r_pend
                    && (rd_data[vdi_pkg::CORE_W-1:0] == r_vtx[vdi_pkg::CORE_W-1:0])
                    && (!i_use_tan || (rd_data[vdi_pkg::VTX_W-1:vdi_pkg::CORE_W]
                                       == r_vtx[vdi_pkg::VTX_W-1:vdi_pkg::CORE_W]));
        done_miss = !r_pend && !issue;
        full      = (r_count == vdi_pkg::CNT_W'(vdi_pkg::TABLE_DEPTH));
        we        = (r_state == ST_SEARCH) && done_miss && !full;
    end

    vdi_ram #(
        .WIDTH (vdi_pkg::VTX_W),
        .DEPTH (vdi_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[vdi_pkg::IDX_W-1:0]),
        .i_wdata (r_vtx),
        .i_re    (issue),
        .i_raddr (r_addr[vdi_pkg::IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_vtx <= i_q_item.vtx;
        end
        if (r_state == ST_SEARCH) begin
            r_pend_addr <= r_addr[vdi_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        if (i_q_item.som) begin
                            r_count <= '0;
                        end
                        r_addr  <= '0;
                        r_pend  <= 1'b0;
                        r_state <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_addr <= r_addr + vdi_pkg::CNT_W'(1);
                    end
                    if (match) begin
                        r_out.idx      <= r_pend_addr;
                        r_out.is_new   <= 1'b0;
                        r_out.overflow <= 1'b0;
                        r_out.count    <= r_count;
                        r_out_valid    <= 1'b1;
                        r_state        <= ST_IDLE;
                    end else if (done_miss) begin
                        if (!full) begin
                            r_out.idx      <= r_count[vdi_pkg::IDX_W-1:0];
                            r_out.is_new   <= 1'b1;
                            r_out.overflow <= 1'b0;
                            r_out.count    <= r_count + vdi_pkg::CNT_W'(1);
                            r_count        <= r_count + vdi_pkg::CNT_W'(1);
                        end else begin
                            r_out.idx      <= '0;
                            r_out.is_new   <= 1'b0;
                            r_out.overflow <= 1'b1;
                            r_out.count    <= r_count;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= vdi_pkg::CNT_W'(vdi_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.is_new && r_out.overflow))
        else $error("new and overflow both set");

    a_append_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> (r_out_valid && r_out.is_new
                && (r_out.count == vdi_pkg::CNT_W'(r_out.idx) + vdi_pkg::CNT_W'(1))))
        else $error("appended index does not match count");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.overflow) |->
            (r_out.idx == '0 && r_out.count == vdi_pkg::CNT_W'(vdi_pkg::TABLE_DEPTH)))
        else $error("overflow without full table");

    a_pop_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == ST_SEARCH && !r_out_valid))
        else $error("search not started after pop");

endmodule

// ===== bench/vdi_index_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vdi_index_checker
// keeps its own table of unique vertices, predicts index, flags and count for
// every accepted vertex item and compares each result item in order
// ----------------------------------------------------------------------------
module vdi_index_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // pos_xy, pos_z_tex_u, nor_xy, nor_z_tex_v, tan_xy, tan_z_hand
    input  logic [vdi_pkg::VTX_W-1:0]      i_s_tdata,
    // start_of_mesh
    input  logic                           i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // vertex_index, is_new, overflow, unique_count, zero pad
    input  logic [vdi_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_accepted,
    output int                             o_added,
    output int                             o_reused,
    output int                             o_refused
);
    import vdi_pkg::*;

    localparam int NEW_BIT = OUT_IDX_W;
    localparam int OVF_BIT = OUT_IDX_W + 1;
    localparam int CNT_LSB = OUT_IDX_W + 2;
    localparam int PAD_LSB = CNT_LSB + OUT_CNT_W;

    logic [VTX_W-1:0] known_vtx [TABLE_DEPTH];
    int               known_count;
    logic             tangents_on;
    t_result          index_due [$];
    int               result_no;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_accepted   = 0;
        o_added      = 0;
        o_reused     = 0;
        o_refused    = 0;
        result_no    = 0;
        known_count  = 0;
        tangents_on  = 1'b0;
    end

    // earliest match wins, a miss appends, a full table refuses
    function automatic t_result index_vertex(input logic som, input logic [VTX_W-1:0] vtx);
        t_result r;
        int      hit;
        int      k;
        if (som) begin
            known_count = 0;
        end
        hit = -1;
        for (k = 0; k < known_count && hit < 0; k++) begin
            if (known_vtx[k][CORE_W-1:0] == vtx[CORE_W-1:0] &&
                (!tangents_on || known_vtx[k][VTX_W-1:CORE_W] == vtx[VTX_W-1:CORE_W])) begin
                hit = k;
            end
        end
        r.is_new   = 1'b0;
        r.overflow = 1'b0;
        if (hit >= 0) begin
            r.idx = hit[IDX_W-1:0];
        end else if (known_count < TABLE_DEPTH) begin
            known_vtx[known_count] = vtx;
            r.idx                  = known_count[IDX_W-1:0];
            r.is_new               = 1'b1;
            known_count++;
        end else begin
            r.idx      = '0;
            r.overflow = 1'b1;
        end
        r.count = known_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic flag_field(input string field, input int unsigned want,
                              input int unsigned seen);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("mismatch, result %0d, %s: expected %0d, got %0d",
                     result_no, field, want, seen);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            known_count = 0;
            tangents_on = 1'b0;
            index_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                result_no++;
                if (index_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("result %0d with nothing due: tdata %h", result_no, i_m_tdata);
                    end
                end else begin
                    want = index_due.pop_front();
                    if (i_m_tdata[OUT_IDX_W-1:0] != want.idx) begin
                        flag_field("vertex_index", want.idx, i_m_tdata[OUT_IDX_W-1:0]);
                    end
                    if (i_m_tdata[NEW_BIT] != want.is_new) begin
                        flag_field("is_new", want.is_new, i_m_tdata[NEW_BIT]);
                    end
                    if (i_m_tdata[OVF_BIT] != want.overflow) begin
                        flag_field("overflow", want.overflow, i_m_tdata[OVF_BIT]);
                    end
                    if (i_m_tdata[CNT_LSB +: OUT_CNT_W] != want.count) begin
                        flag_field("unique_count", want.count, i_m_tdata[CNT_LSB +: OUT_CNT_W]);
                    end
                    if (i_m_tdata[OUT_DATA_W-1:PAD_LSB] != '0) begin
                        flag_field("pad", 0, i_m_tdata[OUT_DATA_W-1:PAD_LSB]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want      = index_vertex(i_s_tuser, i_s_tdata);
                index_due = {index_due, want};
                o_accepted++;
                if (want.overflow) begin
                    o_refused++;
                end else if (want.is_new) begin
                    o_added++;
                end else begin
                    o_reused++;
                end
            end
            // applies from the next item on
            if (i_cfg_we) begin
                tangents_on = i_cfg_wdata;
            end
        end
        o_pending = index_due.size();
    end

endmodule

// ===== bench/tb_vertex_dedup_indexer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_dedup_indexer
// drives vertex items with bursty timing and a stalling receiver: directed
// corner vertices, then random meshes with repeats and near misses under both
// tangent settings
// ----------------------------------------------------------------------------
module tb_vertex_dedup_indexer;
    import vdi_pkg::*;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [VTX_W-1:0]      s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int accepted;
    int added;
    int reused;
    int refused;

    logic [VTX_W-1:0] mesh_vtx [$];
    int               burst_left = 0;
    logic [9:0]       rx_tick    = '0;

    vertex_dedup_indexer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    vdi_index_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_accepted   (accepted),
        .o_added      (added),
        .o_reused     (reused),
        .o_refused    (refused)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver stall pattern, changes character with the top two bits of rx_tick
    always @(negedge clk) begin
        rx_tick <= rx_tick + 10'd1;
        case (rx_tick[9:8])
            2'd0: begin
                m_tready <= 1'b1;
            end
            2'd1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            2'd2: begin
                m_tready <= (rx_tick[2:0] != 3'd0) && (rx_tick[2:0] != 3'd5);
            end
            default: begin
                m_tready <= (rx_tick[4:0] > 5'd20);
            end
        endcase
    end

    function automatic logic [VTX_W-1:0] fresh_vertex();
        logic [VTX_W-1:0] v;
        int               w;
        for (w = 0; w < NUM_WORDS; w++) begin
            case ($urandom_range(0, 7))
                0: v[w*WORD_W +: WORD_W] = '0;
                1: v[w*WORD_W +: WORD_W] = '1;
                2: v[w*WORD_W +: WORD_W] = {32'h8000_0000, $urandom};
                3: v[w*WORD_W +: WORD_W] = {$urandom, 32'h7fc0_0000};
                default: v[w*WORD_W +: WORD_W] = {$urandom, $urandom};
            endcase
        end
        return v;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_vertex(input logic som, input logic [VTX_W-1:0] vtx);
        int gap;
        int seen;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        if (som) begin
            mesh_vtx.delete();
        end
        mesh_vtx = {mesh_vtx, vtx};
        seen = accepted;
        s_tvalid <= 1'b1;
        s_tdata  <= vtx;
        s_tuser  <= som;
        do @(negedge clk); while (accepted == seen);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic set_tangents(input logic on);
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        logic [VTX_W-1:0] v;
        logic [VTX_W-1:0] w;
        logic             som;
        int               ph;
        int               n;
        int               kind;
        int               pick;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corner vertices, tangents ignored, then compared
        send_vertex(1'b1, '0);
        send_vertex(1'b0, '1);
        send_vertex(1'b0, '0);
        send_vertex(1'b0, {{(VTX_W-CORE_W){1'b1}}, {CORE_W{1'b0}}});
        v     = '0;
        v[63] = 1'b1;
        send_vertex(1'b0, v);
        send_vertex(1'b0, {12{32'h7fc0_0001}});
        send_vertex(1'b0, {12{32'h7fc0_0001}});
        send_vertex(1'b0, {6{64'hAAAA_AAAA_AAAA_AAAA}});
        send_vertex(1'b0, {6{64'h5555_5555_5555_5555}});
        send_vertex(1'b0, '1);
        send_vertex(1'b1, '1);
        drain_results();
        set_tangents(1'b1);
        send_vertex(1'b0, {{(VTX_W-CORE_W){1'b0}}, {CORE_W{1'b1}}});
        send_vertex(1'b0, '1);
        send_vertex(1'b0, {{(VTX_W-CORE_W){1'b0}}, {CORE_W{1'b1}}});
        send_vertex(1'b0, {{((VTX_W-CORE_W)/2){2'b10}}, {CORE_W{1'b1}}});

        // random meshes: repeats, tangent-only changes, single-bit near misses
        for (ph = 0; ph < 4; ph++) begin
            if (ph != 0) begin
                drain_results();
                set_tangents(ph[0] == 1'b0);
            end
            for (n = 0; n < 31; n++) begin
                som  = (mesh_vtx.size() == 0) || ($urandom_range(0, 11) == 0);
                kind = $urandom_range(0, 99);
                v    = fresh_vertex();
                if (mesh_vtx.size() != 0 && kind < 70) begin
                    v = mesh_vtx[$urandom_range(0, mesh_vtx.size() - 1)];
                    if (kind >= 60) begin
                        pick    = $urandom_range(0, VTX_W - 1);
                        v[pick] = ~v[pick];
                    end else if (kind >= 45) begin
                        w                   = fresh_vertex();
                        v[VTX_W-1:CORE_W]   = w[VTX_W-1:CORE_W];
                    end
                end
                send_vertex(som, v);
            end
        end

        drain_results();
        send_vertex(1'b1, fresh_vertex());

        drain_results();
        repeat (10) @(negedge clk);
        $display("covered %0d vertex items: %0d added, %0d reused, %0d refused",
                 accepted, added, reused, refused);
        $display("tangent compare switched on and off, mesh restarts, stalls on both sides");
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // about 140 items stay far below this
    initial begin : watchdog
        #(64'd20_000_000);
        $display("timeout with %0d results still due", pending);
        $display("status: fail");
        $finish;
    end

endmodule
